FILE: rtl/core/sid_pkg.sv
// Package for the signed integer divider: operand width, beat types and the
// per-cell work record passed along the divide chain. No dependencies.
`default_nettype none

package sid_pkg;

  localparam int unsigned WIDTH = 32;

  typedef struct packed {
    logic signed [WIDTH-1:0] dividend;
    logic signed [WIDTH-1:0] divisor;
  } sid_in_t;

  typedef struct packed {
    logic signed [WIDTH-1:0] quotient;
    logic                    divide_by_zero;
  } sid_out_t;

  // rem: partial remainder; nq: dividend bits still to shift out on top,
  // quotient bits shifted in from the bottom; den: divisor magnitude.
  typedef struct packed {
    logic [WIDTH-1:0] rem;
    logic [WIDTH-1:0] nq;
    logic [WIDTH-1:0] den;
    logic             neg;
    logic             dbz;
  } sid_work_t;

endpackage

`default_nettype wire

FILE: rtl/core/sid_prep.sv
// Entry stage of the divider: forms operand magnitudes, the result sign and the zero-divisor flag.
// Depends on sid_pkg.
`default_nettype none

module sid_prep (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              valid_i,
  output logic             ready_o,
  input  sid_pkg::sid_in_t data_i,
  output logic             valid_o,
  input  wire              ready_i,
  output sid_pkg::sid_work_t work_o
);
  import sid_pkg::*;

  logic      valid_q;
  sid_work_t work_d, work_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    work_d.rem = '0;
    work_d.nq  = data_i.dividend[WIDTH-1] ? (~data_i.dividend + 1'b1) : data_i.dividend;
    work_d.den = data_i.divisor[WIDTH-1] ? (~data_i.divisor + 1'b1) : data_i.divisor;
    work_d.neg = data_i.dividend[WIDTH-1] ^ data_i.divisor[WIDTH-1];
    work_d.dbz = (data_i.divisor == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      work_q <= work_d;
    end
  end

  assign valid_o = valid_q;
  assign work_o  = work_q;

endmodule

`default_nettype wire

FILE: rtl/core/sid_cell.sv
// One restoring divide step: shift in a dividend bit, trial-subtract the
// divisor, shift the quotient bit in. Depends on sid_pkg.
`default_nettype none

module sid_cell (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                valid_i,
  output logic               ready_o,
  input  sid_pkg::sid_work_t work_i,
  output logic               valid_o,
  input  wire                ready_i,
  output sid_pkg::sid_work_t work_o
);
  import sid_pkg::*;

  logic             valid_q;
  sid_work_t        work_d, work_q;
  logic [WIDTH:0]   rem_sh;
  logic [WIDTH:0]   diff;
  logic             fits;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    rem_sh = {work_i.rem, work_i.nq[WIDTH-1]};
    diff   = rem_sh - {1'b0, work_i.den};
    fits   = !diff[WIDTH];
    work_d     = work_i;
    work_d.rem = fits ? diff[WIDTH-1:0] : rem_sh[WIDTH-1:0];
    work_d.nq  = {work_i.nq[WIDTH-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      work_q <= work_d;
    end
  end

  assign valid_o = valid_q;
  assign work_o  = work_q;

endmodule

`default_nettype wire

FILE: rtl/core/sid_post.sv
// Result stage: applies the sign, saturates the overflow case and zeroes the
// quotient on a zero divisor; holds the output beat. Depends on sid_pkg.
`default_nettype none

module sid_post (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                valid_i,
  output logic               ready_o,
  input  sid_pkg::sid_work_t work_i,
  output logic               valid_o,
  input  wire                ready_i,
  output sid_pkg::sid_out_t  data_o
);
  import sid_pkg::*;

  logic     valid_q;
  sid_out_t data_d, data_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    data_d.divide_by_zero = work_i.dbz;
    if (work_i.dbz) begin
      data_d.quotient = '0;
    end else if (work_i.neg) begin
      data_d.quotient = ~work_i.nq + 1'b1;
    end else if (work_i.nq[WIDTH-1]) begin
      // most negative divided by minus one
      data_d.quotient = {1'b0, {(WIDTH-1){1'b1}}};
    end else begin
      data_d.quotient = work_i.nq;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

FILE: rtl/core/signed_int_divider_unit.sv
// Signed integer divider, quotient truncated toward zero. One operand pair
// is taken per cycle and one result beat comes out per cycle while the
// output is not back-pressured. WIDTH + 2 registered stages: one entry stage
// that forms magnitudes and the sign, a chain of WIDTH restoring-division
// cells with one quotient bit per cell, and one result stage that applies the
// sign. Every stage holds its beat when the next one is full, and a stage
// whose beat has moved on refills in the same cycle, so bubbles close up under
// back-pressure and the input stays ready until all WIDTH + 2 stages are
// occupied. The most negative dividend divided by -1 saturates to the most
// positive value. A zero divisor returns quotient 0 with divide_by_zero set.
// Depends on sid_pkg, sid_prep, sid_cell, sid_post.
`default_nettype none

module signed_int_divider_unit (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_ready_o,
  input  sid_pkg::sid_in_t  in_data_i,
  output logic              out_valid_o,
  input  wire               out_ready_i,
  output sid_pkg::sid_out_t out_data_o
);
  import sid_pkg::*;

  // Chain links: index 0 is the entry stage output, index WIDTH the last cell.
  logic      link_valid [WIDTH+1];
  logic      link_ready [WIDTH+1];
  sid_work_t link_work  [WIDTH+1];

  // Form operand magnitudes, the result sign and the zero-divisor flag.
  sid_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .data_i  (in_data_i),
    .valid_o (link_valid[0]),
    .ready_i (link_ready[0]),
    .work_o  (link_work[0])
  );

  // Advance one quotient bit per cell, most significant bit first.
  for (genvar g = 0; g < WIDTH; g++) begin : g_cell
    sid_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (link_valid[g]),
      .ready_o (link_ready[g]),
      .work_i  (link_work[g]),
      .valid_o (link_valid[g+1]),
      .ready_i (link_ready[g+1]),
      .work_o  (link_work[g+1])
    );
  end

  // Apply sign, saturation and the zero-divisor result; hold the output beat.
  sid_post u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (link_valid[WIDTH]),
    .ready_o (link_ready[WIDTH]),
    .work_i  (link_work[WIDTH]),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_data_o)
  );

endmodule

`default_nettype wire

FILE: rtl/core/sid_checker.sv
// Port-level checks for the signed integer divider, bound to the top level.
// Depends on sid_pkg and signed_int_divider_unit.
`default_nettype none

module sid_checker (
  input wire               clk_i,
  input wire               rst_ni,
  input wire               in_valid_i,
  input wire               in_ready_o,
  input wire               out_valid_o,
  input wire               out_ready_i,
  input sid_pkg::sid_out_t out_data_o
);
  import sid_pkg::*;

  // Hold a stalled output beat.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat changed while stalled");

  // A zero-divisor result carries quotient zero.
  a_dbz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.divide_by_zero |-> out_data_o.quotient == '0)
    else $error("zero divisor result with nonzero quotient");

  // Input back-pressure only when the whole chain is full and stalled.
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output back-pressure");

  // No result beat right after reset.
  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> !out_valid_o)
    else $error("output valid straight out of reset");

endmodule

bind signed_int_divider_unit sid_checker u_sid_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

FILE: dv/signed_int_divider_unit_test.sv
// Self-checking testbench for signed_int_divider_unit: drives directed and random
// operand pairs and checks each result beat against a directed answer or a built-in predictor.
// Depends on sid_pkg and the signed_int_divider_unit RTL only.
`timescale 1ns / 1ps

module signed_int_divider_unit_test;
  import sid_pkg::*;

  localparam logic signed [WIDTH-1:0] MOST_NEG = {1'b1, {(WIDTH-1){1'b0}}};
  localparam logic signed [WIDTH-1:0] MOST_POS = {1'b0, {(WIDTH-1){1'b1}}};
  // Pipeline depth from the block's header.
  localparam int unsigned PIPE_DEPTH = WIDTH + 2;
  localparam int unsigned ITEMS_PER_PHASE = 175;
  localparam int unsigned MAX_PRINTED = 100;

  // One directed row: the operand beat, and the expected result when it is
  // obvious enough to write down (zero divisor, overflow, extremes).
  typedef struct packed {
    sid_in_t  op;
    logic     known;
    sid_out_t want;
  } probe_row_t;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  sid_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  sid_out_t out_data_o;

  sid_out_t    pending_quotients[$];
  probe_row_t  probe_rows[$];
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  signed_int_divider_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) begin
      $display("MISMATCH at %0t: %s", $time, what);
    end
  endtask

  // Truncating signed division done on magnitudes, one quotient bit per step,
  // then the sign applied; positive overflow (most negative / -1) saturates.
  function automatic sid_out_t predict_quotient(input sid_in_t op);
    logic [WIDTH-1:0] num_mag;
    logic [WIDTH-1:0] den_mag;
    logic [WIDTH:0]   partial;
    logic [WIDTH-1:0] quo;
    logic             negate;
    sid_out_t         res;
    res = '0;
    if (op.divisor == '0) begin
      res.divide_by_zero = 1'b1;
      return res;
    end
    negate  = op.dividend[WIDTH-1] ^ op.divisor[WIDTH-1];
    num_mag = op.dividend;
    if (op.dividend[WIDTH-1]) begin
      num_mag = ~num_mag + 1'b1;
    end
    den_mag = op.divisor;
    if (op.divisor[WIDTH-1]) begin
      den_mag = ~den_mag + 1'b1;
    end
    partial = '0;
    quo     = '0;
    for (int i = WIDTH - 1; i >= 0; i--) begin
      partial = {partial[WIDTH-1:0], num_mag[i]};
      if (partial >= {1'b0, den_mag}) begin
        partial = partial - {1'b0, den_mag};
        quo[i]  = 1'b1;
      end
    end
    if (negate) begin
      quo = ~quo + 1'b1;
    end else if (quo > MOST_POS) begin
      quo = MOST_POS;
    end
    res.quotient = quo;
    return res;
  endfunction

  function automatic logic signed [WIDTH-1:0] corner_value(input int unsigned sel);
    case (sel)
      0:       return MOST_NEG;
      1:       return MOST_POS;
      2:       return '0;
      3:       return 1;
      default: return -1;
    endcase
  endfunction

  // Mix of operand shapes: full-range pairs mostly give 0 or +-1, so shrink
  // the divisor (and sometimes both) by a random arithmetic shift to spread
  // the quotients over all magnitudes.
  function automatic sid_in_t random_operands();
    sid_in_t     op;
    int unsigned pick;
    pick        = $urandom_range(99, 0);
    op.dividend = $urandom;
    op.divisor  = $urandom;
    if (pick < 5) begin
      op.divisor = '0;
    end else if (pick < 15) begin
      op.dividend = corner_value($urandom_range(4, 0));
      op.divisor  = corner_value($urandom_range(4, 0));
    end else if (pick < 55) begin
      op.divisor = op.divisor >>> $urandom_range(WIDTH - 1, 1);
    end else if (pick < 80) begin
      op.dividend = op.dividend >>> $urandom_range(WIDTH - 1, 0);
      op.divisor  = op.divisor >>> $urandom_range(WIDTH - 1, 0);
    end
    return op;
  endfunction

  task automatic add_probe(input logic signed [WIDTH-1:0] dividend,
                           input logic signed [WIDTH-1:0] divisor,
                           input logic known,
                           input logic signed [WIDTH-1:0] quotient,
                           input logic dbz);
    probe_row_t row;
    row.op.dividend          = dividend;
    row.op.divisor           = divisor;
    row.known                = known;
    row.want.quotient        = quotient;
    row.want.divide_by_zero  = dbz;
    probe_rows.push_back(row);
  endtask

  // Present one operand beat, idling first at the current rate, and hold it
  // until the handshake completes. The expectation is queued at acceptance.
  task automatic push_operands(input sid_in_t op, input sid_out_t want);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= op;
    @(posedge clk_i);
    while (!in_ready_o) begin
      @(posedge clk_i);
    end
    pending_quotients.push_back(want);
  endtask

  // Drop valid and hold off the sender until every queued result is back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_quotients.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct);
    sid_in_t op;
    drain_results();
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
      op = random_operands();
      push_operands(op, predict_quotient(op));
    end
  endtask

  // Result side: compare each accepted beat with the oldest expectation,
  // then choose ready for the next cycle at the current stall rate.
  always @(posedge clk_i) begin
    sid_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_quotients.size() == 0) begin
        flag_mismatch($sformatf("result beat with nothing pending: q=%0d dbz=%0b",
                                out_data_o.quotient, out_data_o.divide_by_zero));
      end else begin
        want = pending_quotients.pop_front();
        if (out_data_o.quotient !== want.quotient) begin
          flag_mismatch($sformatf("quotient %h, expected %h",
                                  out_data_o.quotient, want.quotient));
        end
        if (out_data_o.divide_by_zero !== want.divide_by_zero) begin
          flag_mismatch($sformatf("divide_by_zero %b, expected %b",
                                  out_data_o.divide_by_zero, want.divide_by_zero));
        end
      end
    end
    out_ready_i <= ($urandom_range(99, 0) >= recv_stall_pct);
  end

  initial begin
    probe_row_t row;

    // Directed table. Rows with known = 1 carry their answer; the rest are
    // checked against the predictor.
    add_probe('0,               '0,               1'b1, '0,           1'b1);
    add_probe(MOST_POS,         '0,               1'b1, '0,           1'b1);
    add_probe(MOST_NEG,         '0,               1'b1, '0,           1'b1);
    add_probe(MOST_NEG,         -1,               1'b1, MOST_POS,     1'b0);
    add_probe(MOST_NEG,         1,                1'b1, MOST_NEG,     1'b0);
    add_probe(MOST_POS,         1,                1'b1, MOST_POS,     1'b0);
    add_probe(MOST_POS,         -1,               1'b1, -MOST_POS,    1'b0);
    add_probe(MOST_NEG,         MOST_NEG,         1'b1, 1,            1'b0);
    add_probe(MOST_POS,         MOST_POS,         1'b1, 1,            1'b0);
    add_probe(MOST_POS,         MOST_NEG,         1'b1, '0,           1'b0);
    add_probe(MOST_NEG,         MOST_POS,         1'b1, -1,           1'b0);
    add_probe('0,               MOST_NEG,         1'b1, '0,           1'b0);
    add_probe(-1,               MOST_NEG,         1'b1, '0,           1'b0);
    add_probe(1,                -1,               1'b1, -1,           1'b0);
    add_probe(-1,               -1,               1'b1, 1,            1'b0);
    add_probe(7,                2,                1'b0, '0,           1'b0);
    add_probe(-7,               2,                1'b0, '0,           1'b0);
    add_probe(7,                -2,               1'b0, '0,           1'b0);
    add_probe(-7,               -2,               1'b0, '0,           1'b0);
    add_probe(32'h5555_5555,    32'hAAAA_AAAA,    1'b0, '0,           1'b0);
    add_probe(32'hAAAA_AAAA,    3,                1'b0, '0,           1'b0);
    add_probe(1,                2,                1'b0, '0,           1'b0);
    add_probe(MOST_NEG,         2,                1'b0, '0,           1'b0);
    add_probe(100000,           7,                1'b0, '0,           1'b0);

    // Hold reset, then release it for good.
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows back to back, receiver always ready.
    foreach (probe_rows[k]) begin
      row = probe_rows[k];
      push_operands(row.op, row.known ? row.want : predict_quotient(row.op));
    end

    // Random phases; each one starts by pausing until the pipe is empty.
    run_phase(0, 0);
    run_phase(81, 0);
    run_phase(0, 81);
    run_phase(22, 22);

    drain_results();
    // Watch a little past the pipeline depth for stray result beats.
    repeat (PIPE_DEPTH + 8) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
